// ===== sv/mhs_pkg.sv =====
// Package with the constants, types and widths of the HMAC-SHA1 engine.
`default_nettype none
package mhs_pkg;

   localparam int KEY_WIDTH   = 64;
   localparam int NONCE_WIDTH = 32;
   localparam int WORD_WIDTH  = 32;
   localparam int INDEX_WIDTH = 3;
   localparam int ROUND_WIDTH = 7;
   localparam int PHASE_WIDTH = 2;

   localparam int DIGEST_WORDS = 5;
   localparam int SCHED_DEPTH  = 16;

   localparam logic [ROUND_WIDTH-1:0] LAST_ROUND = 7'd79;
   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = 3'd4;

   localparam logic [WORD_WIDTH-1:0] K_ROUND0 = 32'h5a827999;
   localparam logic [WORD_WIDTH-1:0] K_ROUND1 = 32'h6ed9eba1;
   localparam logic [WORD_WIDTH-1:0] K_ROUND2 = 32'h8f1bbcdc;
   localparam logic [WORD_WIDTH-1:0] K_ROUND3 = 32'hca62c1d6;

   localparam logic [WORD_WIDTH-1:0] IV_WORD0 = 32'h67452301;
   localparam logic [WORD_WIDTH-1:0] IV_WORD1 = 32'hefcdab89;
   localparam logic [WORD_WIDTH-1:0] IV_WORD2 = 32'h98badcfe;
   localparam logic [WORD_WIDTH-1:0] IV_WORD3 = 32'h10325476;
   localparam logic [WORD_WIDTH-1:0] IV_WORD4 = 32'hc3d2e1f0;

   localparam logic [WORD_WIDTH-1:0] IPAD_WORD   = 32'h36363636;
   localparam logic [WORD_WIDTH-1:0] OPAD_WORD   = 32'h5c5c5c5c;
   localparam logic [WORD_WIDTH-1:0] PAD_MARK    = 32'h80000000;
   localparam logic [WORD_WIDTH-1:0] INNER_BITS  = 32'd576;
   localparam logic [WORD_WIDTH-1:0] OUTER_BITS  = 32'd672;

   localparam logic [PHASE_WIDTH-1:0] PHASE_INNER_KEY = 2'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_INNER_MSG = 2'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_OUTER_KEY = 2'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_OUTER_MSG = 2'd3;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_ROUND  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

endpackage
`default_nettype wire

// ===== sv/mhs_if.sv =====
// Request and response channel interfaces of the HMAC-SHA1 engine.
`default_nettype none
interface mhs_req_if
   import mhs_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [KEY_WIDTH-1:0]   first_key;
   logic [KEY_WIDTH-1:0]   second_key;
   logic [NONCE_WIDTH-1:0] first_nonce;
   logic [NONCE_WIDTH-1:0] second_nonce;

   modport source (output valid, first_key, second_key, first_nonce, second_nonce,
                   input ready);
   modport sink (input valid, first_key, second_key, first_nonce, second_nonce,
                 output ready);
endinterface

interface mhs_rsp_if
   import mhs_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [WORD_WIDTH-1:0]  digest_word;
   logic [INDEX_WIDTH-1:0] word_index;
   logic                   last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== sv/mptcp_hmac_sha1_engine_unit.sv =====
// HMAC-SHA1 engine for a 16-byte key and an 8-byte message.
//
// A request beat on req_bus carries two 64-bit keys and two 32-bit nonces. The
// engine runs four SHA-1 compressions through one round unit, one round per
// cycle, and then returns five response beats on rsp_bus: the digest words H0
// to H4, each with its index, the last one flagged by last_word.
// Each compression loads the working variables, runs 80 rounds and then adds
// the result into the chaining value. The first response beat follows the
// fourth compression, and a new request is accepted only once the last
// response beat has been taken. One round unit with its single five-input
// adder performs every round.
// req_bus.ready is high only while the engine is idle. When the receiver
// stalls, the current response beat holds its value and the engine waits.
// A synchronous reset returns the engine to idle with no response pending.
`default_nettype none
module mptcp_hmac_sha1_engine_unit
   import mhs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mhs_req_if.sink    req_bus,
   mhs_rsp_if.source  rsp_bus
);

   state_type               state_ff, state_in;
   logic [ROUND_WIDTH-1:0]  round_ff, round_in;
   logic [PHASE_WIDTH-1:0]  phase_ff, phase_in;
   logic [INDEX_WIDTH-1:0]  emit_ff, emit_in;

   logic [KEY_WIDTH-1:0]    key0_ff, key1_ff;
   logic [NONCE_WIDTH-1:0]  nonce0_ff, nonce1_ff;
   word_type                chain_ff [DIGEST_WORDS];
   word_type                inner_ff [DIGEST_WORDS];
   word_type                wv_ff    [DIGEST_WORDS];
   word_type                sched_ff [SCHED_DEPTH];

   word_type                block_word;
   word_type                sched_word;
   word_type                round_word;
   word_type                f_value;
   word_type                k_value;
   word_type                temp_sum;
   word_type                iv [DIGEST_WORDS];

   assign iv[0] = IV_WORD0;
   assign iv[1] = IV_WORD1;
   assign iv[2] = IV_WORD2;
   assign iv[3] = IV_WORD3;
   assign iv[4] = IV_WORD4;

   always_comb begin
      logic [3:0] pos;
      word_type   pad;
      pos = round_ff[3:0];
      pad = (phase_ff == PHASE_INNER_KEY) ? IPAD_WORD : OPAD_WORD;
      block_word = '0;
      unique case (phase_ff)
         PHASE_INNER_KEY, PHASE_OUTER_KEY: begin
            case (pos)
               4'd0:    block_word = pad ^ key0_ff[KEY_WIDTH-1 -: WORD_WIDTH];
               4'd1:    block_word = pad ^ key0_ff[WORD_WIDTH-1:0];
               4'd2:    block_word = pad ^ key1_ff[KEY_WIDTH-1 -: WORD_WIDTH];
               4'd3:    block_word = pad ^ key1_ff[WORD_WIDTH-1:0];
               default: block_word = pad;
            endcase
         end
         PHASE_INNER_MSG: begin
            case (pos)
               4'd0:    block_word = nonce0_ff;
               4'd1:    block_word = nonce1_ff;
               4'd2:    block_word = PAD_MARK;
               4'd15:   block_word = INNER_BITS;
               default: block_word = '0;
            endcase
         end
         PHASE_OUTER_MSG: begin
            case (pos) inside
               [4'd0:4'd4]: block_word = inner_ff[pos[2:0]];
               4'd5:        block_word = PAD_MARK;
               4'd15:       block_word = OUTER_BITS;
               default:     block_word = '0;
            endcase
         end
         default: block_word = '0;
      endcase
   end

   always_comb begin
      word_type mix;
      mix = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      sched_word = {mix[WORD_WIDTH-2:0], mix[WORD_WIDTH-1]};
      round_word = (round_ff < 7'd16) ? block_word : sched_word;
   end

   always_comb begin
      word_type b, c, d;
      b = wv_ff[1];
      c = wv_ff[2];
      d = wv_ff[3];
      if (round_ff < 7'd20) begin
         f_value = (b & c) | (~b & d);
         k_value = K_ROUND0;
      end else if (round_ff < 7'd40) begin
         f_value = b ^ c ^ d;
         k_value = K_ROUND1;
      end else if (round_ff < 7'd60) begin
         f_value = (b & c) | (b & d) | (c & d);
         k_value = K_ROUND2;
      end else begin
         f_value = b ^ c ^ d;
         k_value = K_ROUND3;
      end
      temp_sum = {wv_ff[0][WORD_WIDTH-6:0], wv_ff[0][WORD_WIDTH-1 -: 5]}
               + f_value + wv_ff[4] + k_value + round_word;
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      phase_in = phase_ff;
      emit_in  = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_LOAD;
               phase_in = PHASE_INNER_KEY;
               round_in = '0;
               emit_in  = '0;
            end
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
               round_in = '0;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_FINISH: begin
            if (phase_ff == PHASE_OUTER_MSG) begin
               state_in = ST_EMIT;
               phase_in = PHASE_INNER_KEY;
            end else begin
               state_in = ST_LOAD;
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            if (rsp_bus.ready) begin
               if (emit_ff == LAST_INDEX) begin
                  state_in = ST_IDLE;
                  emit_in  = '0;
               end else begin
                  emit_in = emit_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         phase_ff <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         phase_ff <= phase_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_bus.valid) begin
         key0_ff   <= req_bus.first_key;
         key1_ff   <= req_bus.second_key;
         nonce0_ff <= req_bus.first_nonce;
         nonce1_ff <= req_bus.second_nonce;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= iv[i];
         end
      end
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            wv_ff[i] <= chain_ff[i];
         end
      end
      if (state_ff == ST_ROUND) begin
         wv_ff[4] <= wv_ff[3];
         wv_ff[3] <= wv_ff[2];
         wv_ff[2] <= {wv_ff[1][1:0], wv_ff[1][WORD_WIDTH-1:2]};
         wv_ff[1] <= wv_ff[0];
         wv_ff[0] <= temp_sum;
         for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[SCHED_DEPTH-1] <= round_word;
      end
      if (state_ff == ST_FINISH) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            if (phase_ff == PHASE_INNER_MSG) begin
               inner_ff[i] <= chain_ff[i] + wv_ff[i];
               chain_ff[i] <= iv[i];
            end else begin
               chain_ff[i] <= chain_ff[i] + wv_ff[i];
            end
         end
      end
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_EMIT);
   assign rsp_bus.digest_word = chain_ff[emit_ff];
   assign rsp_bus.word_index  = emit_ff;
   assign rsp_bus.last_word   = (emit_ff == LAST_INDEX);

endmodule
`default_nettype wire
